// ----- hdl/rv64i_instruction_decoder_unit_defines.svh -----
// Assertion macros shared by the decoder's checker.
// Needs a clock named clk and a reset named rst where the macros are used.
`ifndef RV64I_INSTRUCTION_DECODER_UNIT_DEFINES_SVH
`define RV64I_INSTRUCTION_DECODER_UNIT_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define RVID_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define RVID_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hdl/rvid_pkg.sv -----
// Shared types and codes for the RV64I instruction decoder.
// No dependencies; used by the decode logic, the top level and the checker.
package rvid_pkg;

  localparam int INSTR_W = 32;
  localparam int OP_W    = 6;
  localparam int LAY_W   = 3;
  localparam int REG_W   = 5;
  localparam int IMM_W   = 21;

  localparam logic [6:0] OPC_R      = 7'b0110011;
  localparam logic [6:0] OPC_I_ALU  = 7'b0010011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;

  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  // Function-3 codes of the ALU, load, store and branch classes.
  localparam logic [2:0] F3_ADD  = 3'b000;
  localparam logic [2:0] F3_SLL  = 3'b001;
  localparam logic [2:0] F3_XOR  = 3'b100;
  localparam logic [2:0] F3_SR   = 3'b101;
  localparam logic [2:0] F3_OR   = 3'b110;
  localparam logic [2:0] F3_AND  = 3'b111;

  localparam logic [2:0] F3_LB   = 3'b000;
  localparam logic [2:0] F3_LH   = 3'b001;
  localparam logic [2:0] F3_LW   = 3'b010;
  localparam logic [2:0] F3_LD   = 3'b011;
  localparam logic [2:0] F3_LBU  = 3'b100;
  localparam logic [2:0] F3_LHU  = 3'b101;
  localparam logic [2:0] F3_LWU  = 3'b110;

  localparam logic [2:0] F3_SB   = 3'b000;
  localparam logic [2:0] F3_SH   = 3'b001;
  localparam logic [2:0] F3_SW   = 3'b010;
  localparam logic [2:0] F3_SD   = 3'b011;

  localparam logic [2:0] F3_BEQ  = 3'b000;
  localparam logic [2:0] F3_BNE  = 3'b001;
  localparam logic [2:0] F3_BLT  = 3'b100;
  localparam logic [2:0] F3_BGE  = 3'b101;
  localparam logic [2:0] F3_BLTU = 3'b110;
  localparam logic [2:0] F3_BGEU = 3'b111;

  typedef enum logic [OP_W-1:0] {
    OP_UNKNOWN = 6'd0,
    OP_ADD  = 6'd1,  OP_SUB  = 6'd2,  OP_XOR  = 6'd3,  OP_OR   = 6'd4,
    OP_AND  = 6'd5,  OP_SLL  = 6'd6,  OP_SRL  = 6'd7,  OP_SRA  = 6'd8,
    OP_ADDI = 6'd9,  OP_XORI = 6'd10, OP_ORI  = 6'd11, OP_ANDI = 6'd12,
    OP_SLLI = 6'd13, OP_SRLI = 6'd14, OP_SRAI = 6'd15,
    OP_LB   = 6'd16, OP_LH   = 6'd17, OP_LW   = 6'd18, OP_LD   = 6'd19,
    OP_LBU  = 6'd20, OP_LHU  = 6'd21, OP_LWU  = 6'd22, OP_JALR = 6'd23,
    OP_SB   = 6'd24, OP_SH   = 6'd25, OP_SW   = 6'd26, OP_SD   = 6'd27,
    OP_BEQ  = 6'd28, OP_BNE  = 6'd29, OP_BLT  = 6'd30, OP_BGE  = 6'd31,
    OP_BLTU = 6'd32, OP_BGEU = 6'd33, OP_JAL  = 6'd34, OP_LUI  = 6'd35
  } op_t;

  typedef enum logic [LAY_W-1:0] {
    LAY_R      = 3'd0,
    LAY_I_ALU  = 3'd1,
    LAY_LOAD   = 3'd2,
    LAY_JALR   = 3'd3,
    LAY_STORE  = 3'd4,
    LAY_BRANCH = 3'd5,
    LAY_JAL    = 3'd6,
    LAY_LUI    = 3'd7
  } layout_t;

  typedef struct packed {
    logic                     handled;
    op_t                      op;
    layout_t                  lay;
    logic [REG_W-1:0]         rd;
    logic [REG_W-1:0]         rs1;
    logic [REG_W-1:0]         rs2;
    logic signed [IMM_W-1:0]  imm;
  } decode_t;

endpackage

// ----- hdl/rvid_decode.sv -----
// Combinational decode of one instruction word into operation, layout,
// register fields and immediate. Depends on rvid_pkg.
module rvid_decode
  import rvid_pkg::*;
(
  input  logic [INSTR_W-1:0] word,
  output decode_t            dec
);

  logic [6:0] opc;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [5:0] top6;
  logic signed [IMM_W-1:0] imm_i;
  logic signed [IMM_W-1:0] imm_s;
  logic signed [IMM_W-1:0] imm_b;
  logic signed [IMM_W-1:0] imm_j;
  logic signed [IMM_W-1:0] imm_u;
  logic signed [IMM_W-1:0] imm_sh;

  assign opc  = word[6:0];
  assign f3   = word[14:12];
  assign f7   = word[31:25];
  assign top6 = word[31:26];

  assign imm_i  = {{(IMM_W-12){word[31]}}, word[31:20]};
  assign imm_s  = {{(IMM_W-12){word[31]}}, word[31:25], word[11:7]};
  assign imm_b  = {{(IMM_W-13){word[31]}}, word[31], word[7], word[30:25],
                   word[11:8], 1'b0};
  assign imm_j  = {word[31], word[19:12], word[20], word[30:21], 1'b0};
  // The lui field is passed raw, so it is zero-extended, not sign-extended.
  assign imm_u  = {1'b0, word[31:12]};
  assign imm_sh = {{(IMM_W-6){1'b0}}, word[25:20]};

  always_comb begin
    dec.handled = 1'b1;
    dec.op      = OP_UNKNOWN;
    dec.lay     = LAY_R;
    dec.rd      = word[11:7];
    dec.rs1     = word[19:15];
    dec.rs2     = word[24:20];
    dec.imm     = '0;
    case (opc)
      OPC_R: begin
        dec.lay = LAY_R;
        if (f7 == F7_BASE) begin
          case (f3)
            F3_ADD:  dec.op = OP_ADD;
            F3_XOR:  dec.op = OP_XOR;
            F3_OR:   dec.op = OP_OR;
            F3_AND:  dec.op = OP_AND;
            F3_SLL:  dec.op = OP_SLL;
            F3_SR:   dec.op = OP_SRL;
            default: dec.op = OP_UNKNOWN;
          endcase
        end else if (f7 == F7_ALT) begin
          if (f3 == F3_ADD) dec.op = OP_SUB;
          else if (f3 == F3_SR) dec.op = OP_SRA;
        end
      end
      OPC_I_ALU: begin
        dec.lay = LAY_I_ALU;
        dec.rs2 = '0;
        dec.imm = imm_i;
        case (f3)
          F3_ADD: dec.op = OP_ADDI;
          F3_XOR: dec.op = OP_XORI;
          F3_OR:  dec.op = OP_ORI;
          F3_AND: dec.op = OP_ANDI;
          F3_SLL: begin
            // A left shift with upper bits set is not legal and keeps the
            // ordinary 12-bit immediate.
            if (top6 == 6'd0) begin
              dec.op  = OP_SLLI;
              dec.imm = imm_sh;
            end
          end
          F3_SR: begin
            dec.op  = (top6 == 6'd0) ? OP_SRLI : OP_SRAI;
            dec.imm = imm_sh;
          end
          default: dec.op = OP_UNKNOWN;
        endcase
      end
      OPC_LOAD: begin
        dec.lay = LAY_LOAD;
        dec.rs2 = '0;
        dec.imm = imm_i;
        case (f3)
          F3_LB:   dec.op = OP_LB;
          F3_LH:   dec.op = OP_LH;
          F3_LW:   dec.op = OP_LW;
          F3_LD:   dec.op = OP_LD;
          F3_LBU:  dec.op = OP_LBU;
          F3_LHU:  dec.op = OP_LHU;
          F3_LWU:  dec.op = OP_LWU;
          default: dec.op = OP_UNKNOWN;
        endcase
      end
      OPC_JALR: begin
        dec.lay = LAY_JALR;
        dec.rs2 = '0;
        dec.imm = imm_i;
        dec.op  = OP_JALR;
      end
      OPC_STORE: begin
        dec.lay = LAY_STORE;
        dec.rd  = '0;
        dec.imm = imm_s;
        case (f3)
          F3_SB:   dec.op = OP_SB;
          F3_SH:   dec.op = OP_SH;
          F3_SW:   dec.op = OP_SW;
          F3_SD:   dec.op = OP_SD;
          default: dec.op = OP_UNKNOWN;
        endcase
      end
      OPC_BRANCH: begin
        dec.lay = LAY_BRANCH;
        dec.rd  = '0;
        dec.imm = imm_b;
        case (f3)
          F3_BEQ:  dec.op = OP_BEQ;
          F3_BNE:  dec.op = OP_BNE;
          F3_BLT:  dec.op = OP_BLT;
          F3_BGE:  dec.op = OP_BGE;
          F3_BLTU: dec.op = OP_BLTU;
          F3_BGEU: dec.op = OP_BGEU;
          default: dec.op = OP_UNKNOWN;
        endcase
      end
      OPC_JAL: begin
        dec.lay = LAY_JAL;
        dec.rs1 = '0;
        dec.rs2 = '0;
        dec.imm = imm_j;
        dec.op  = OP_JAL;
      end
      OPC_LUI: begin
        dec.lay = LAY_LUI;
        dec.rs1 = '0;
        dec.rs2 = '0;
        dec.imm = imm_u;
        dec.op  = OP_LUI;
      end
      default: dec.handled = 1'b0;
    endcase
  end

endmodule

// ----- hdl/rv64i_instruction_decoder_unit.sv -----
// Top level of the RV64I instruction decoder: input register, decode logic
// and result register. Depends on rvid_pkg and rvid_decode.

// One instruction word is taken per request whenever start is high; busy is
// always low, so a request may be issued in every clock cycle. The result
// passes through the input register and then the result register, and is
// shown for exactly one cycle with done high; the receiver cannot stall it.
// A word whose major opcode is not one of the eight handled classes gives no
// result and done stays low for it. The figure of one word per cycle is set
// by the single decode pass between the two registers.
module rv64i_instruction_decoder_unit
  import rvid_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [INSTR_W-1:0]       instr_word,
  output logic                     done,
  output logic [OP_W-1:0]          op_id,
  output logic [LAY_W-1:0]         layout,
  output logic [REG_W-1:0]         dest_reg,
  output logic [REG_W-1:0]         src1_reg,
  output logic [REG_W-1:0]         src2_reg,
  output logic signed [IMM_W-1:0]  immediate
);

  logic               in_valid;
  logic [INSTR_W-1:0] in_word;
  decode_t            dec;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    if (start && !busy) begin
      in_word <= instr_word;
    end
  end

  rvid_decode u_decode (
    .word (in_word),
    .dec  (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid && dec.handled;
    end
    op_id     <= dec.op;
    layout    <= dec.lay;
    dest_reg  <= dec.rd;
    src1_reg  <= dec.rs1;
    src2_reg  <= dec.rs2;
    immediate <= dec.imm;
  end

endmodule

// ----- hdl/rvid_checker.sv -----
// Port-level checks for the RV64I instruction decoder, bound to the top level.
// Depends on rvid_pkg and rv64i_instruction_decoder_unit_defines.svh.
`include "rv64i_instruction_decoder_unit_defines.svh"

module rvid_checker
  import rvid_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic [INSTR_W-1:0]       instr_word,
  input logic                     done,
  input logic [OP_W-1:0]          op_id,
  input logic [LAY_W-1:0]         layout,
  input logic [REG_W-1:0]         dest_reg,
  input logic [REG_W-1:0]         src1_reg,
  input logic [REG_W-1:0]         src2_reg,
  input logic signed [IMM_W-1:0]  immediate
);

  logic [6:0] opc_d1;
  logic [6:0] opc_d2;
  logic       req_d1;
  logic       req_d2;
  logic       opc_known;
  logic       rd_unused;
  logic       lui_ok;

  // Requests and their opcodes pass through the d1 and then the d2 register to line up with done.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_d1 <= 1'b0;
      req_d2 <= 1'b0;
    end else begin
      req_d1 <= start && !busy;
      req_d2 <= req_d1;
    end
    opc_d1 <= instr_word[6:0];
    opc_d2 <= opc_d1;
  end

  assign opc_known = (opc_d2 == OPC_R) || (opc_d2 == OPC_I_ALU) ||
                     (opc_d2 == OPC_LOAD) || (opc_d2 == OPC_JALR) ||
                     (opc_d2 == OPC_STORE) || (opc_d2 == OPC_BRANCH) ||
                     (opc_d2 == OPC_JAL) || (opc_d2 == OPC_LUI);
  assign rd_unused = (layout == LAY_STORE) || (layout == LAY_BRANCH);
  assign lui_ok    = (op_id == OP_LUI) && (src1_reg == '0) && (src2_reg == '0) &&
                     !immediate[IMM_W-1];

  // A result only follows a request that has passed through both delay registers.
  `RVID_ASSERT_IMPLY(a_done_has_request, done, req_d2, "result without a request")

  // A request with an opcode outside the handled classes yields no result.
  `RVID_ASSERT_IMPLY(a_unhandled_silent, req_d2 && !opc_known, !done, "unhandled result")

  // Register-register operations carry no immediate.
  `RVID_ASSERT_IMPLY(a_r_imm_zero, done && (layout == LAY_R), immediate == '0, "R immediate set")

  // Stores and branches write no register.
  `RVID_ASSERT_IMPLY(a_no_rd, done && rd_unused, dest_reg == '0, "rd set for store or branch")

  // An upper-immediate load reads no registers and its field is never negative.
  `RVID_ASSERT_IMPLY(a_lui_fields, done && (layout == LAY_LUI), lui_ok, "lui fields wrong")

endmodule

bind rv64i_instruction_decoder_unit rvid_checker u_rvid_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .instr_word (instr_word),
  .done       (done),
  .op_id      (op_id),
  .layout     (layout),
  .dest_reg   (dest_reg),
  .src1_reg   (src1_reg),
  .src2_reg   (src2_reg),
  .immediate  (immediate)
);

// ----- tb/sv/rv64i_instruction_decoder_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the RV64I instruction decoder: directed words for every
// operation and the awkward funct cases, then a long stream of shaped random words.
// Depends on rvid_pkg and the rv64i_instruction_decoder_unit top level.
module rv64i_instruction_decoder_unit_test;
  import rvid_pkg::*;

  localparam int RANDOM_WORDS = 1900;
  localparam int REPORT_LIMIT = 10;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [INSTR_W-1:0]      instr_word;
  logic                    done;
  logic [OP_W-1:0]         op_id;
  logic [LAY_W-1:0]        layout;
  logic [REG_W-1:0]        dest_reg;
  logic [REG_W-1:0]        src1_reg;
  logic [REG_W-1:0]        src2_reg;
  logic signed [IMM_W-1:0] immediate;

  decode_t     pending_decodes[$];
  int unsigned max_gap;
  int unsigned requests_sent;
  int unsigned results_checked;
  int unsigned words_without_result;
  int unsigned mismatch_count;

  rv64i_instruction_decoder_unit dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .instr_word (instr_word),
    .done       (done),
    .op_id      (op_id),
    .layout     (layout),
    .dest_reg   (dest_reg),
    .src1_reg   (src1_reg),
    .src2_reg   (src2_reg),
    .immediate  (immediate)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Works out the decode of one word; handled is low where no result is due.
  function automatic decode_t predict_decode(input logic [INSTR_W-1:0] w);
    decode_t    d;
    logic [6:0] f7;
    logic [2:0] f3;
    logic [5:0] top6;
    f7 = w[31:25];
    f3 = w[14:12];
    top6 = w[31:26];
    d.handled = 1'b1;
    d.op = OP_UNKNOWN;
    d.lay = LAY_R;
    d.rd = w[11:7];
    d.rs1 = w[19:15];
    d.rs2 = w[24:20];
    d.imm = '0;
    case (w[6:0])
      OPC_R: begin
        d.lay = LAY_R;
        if (f7 == F7_BASE) begin
          case (f3)
            F3_ADD: d.op = OP_ADD;
            F3_XOR: d.op = OP_XOR;
            F3_OR:  d.op = OP_OR;
            F3_AND: d.op = OP_AND;
            F3_SLL: d.op = OP_SLL;
            F3_SR:  d.op = OP_SRL;
            default: d.op = OP_UNKNOWN;
          endcase
        end else if (f7 == F7_ALT) begin
          if (f3 == F3_ADD) d.op = OP_SUB;
          else if (f3 == F3_SR) d.op = OP_SRA;
        end
      end
      OPC_I_ALU: begin
        d.lay = LAY_I_ALU;
        d.rs2 = '0;
        d.imm = {{9{w[31]}}, w[31:20]};
        case (f3)
          F3_ADD: d.op = OP_ADDI;
          F3_XOR: d.op = OP_XORI;
          F3_OR:  d.op = OP_ORI;
          F3_AND: d.op = OP_ANDI;
          F3_SLL: begin
            // A left shift with a nonzero upper field stays unknown and keeps
            // the sign-extended immediate.
            if (top6 == 6'd0) begin
              d.op = OP_SLLI;
              d.imm = {15'd0, w[25:20]};
            end
          end
          F3_SR: begin
            d.op = (top6 == 6'd0) ? OP_SRLI : OP_SRAI;
            d.imm = {15'd0, w[25:20]};
          end
          default: d.op = OP_UNKNOWN;
        endcase
      end
      OPC_LOAD: begin
        d.lay = LAY_LOAD;
        d.rs2 = '0;
        d.imm = {{9{w[31]}}, w[31:20]};
        d.op = (f3 <= F3_LWU) ? op_t'(OP_LB + f3) : OP_UNKNOWN;
      end
      OPC_JALR: begin
        d.lay = LAY_JALR;
        d.rs2 = '0;
        d.imm = {{9{w[31]}}, w[31:20]};
        d.op = OP_JALR;
      end
      OPC_STORE: begin
        d.lay = LAY_STORE;
        d.rd = '0;
        d.imm = {{9{w[31]}}, w[31:25], w[11:7]};
        d.op = (f3 <= F3_SD) ? op_t'(OP_SB + f3) : OP_UNKNOWN;
      end
      OPC_BRANCH: begin
        d.lay = LAY_BRANCH;
        d.rd = '0;
        d.imm = {{8{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        case (f3)
          F3_BEQ:  d.op = OP_BEQ;
          F3_BNE:  d.op = OP_BNE;
          F3_BLT:  d.op = OP_BLT;
          F3_BGE:  d.op = OP_BGE;
          F3_BLTU: d.op = OP_BLTU;
          F3_BGEU: d.op = OP_BGEU;
          default: d.op = OP_UNKNOWN;
        endcase
      end
      OPC_JAL: begin
        d.lay = LAY_JAL;
        d.rs1 = '0;
        d.rs2 = '0;
        d.imm = {w[31], w[19:12], w[20], w[30:21], 1'b0};
        d.op = OP_JAL;
      end
      OPC_LUI: begin
        d.lay = LAY_LUI;
        d.rs1 = '0;
        d.rs2 = '0;
        d.imm = {1'b0, w[31:12]};
        d.op = OP_LUI;
      end
      default: d.handled = 1'b0;
    endcase
    return d;
  endfunction

  // Issues one request after a random gap and records what it should produce.
  task automatic send_request(input logic [INSTR_W-1:0] word);
    int unsigned gap;
    decode_t     want;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    instr_word <= word;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = predict_decode(word);
    requests_sent++;
    if (want.handled) pending_decodes = {pending_decodes, want};
    else words_without_result++;
  endtask

  // Builds a word from its funct fields, with every register field all ones or all zeros.
  task automatic send_fields(input logic [6:0] f7, input logic [2:0] f3, input logic [6:0] opc,
                             input logic fill);
    send_request({f7, {5{fill}}, {5{fill}}, f3, {5{fill}}, opc});
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_decodes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [6:0] pick_handled_opcode();
    case ($urandom_range(0, 7))
      0: return OPC_R;
      1: return OPC_I_ALU;
      2: return OPC_LOAD;
      3: return OPC_JALR;
      4: return OPC_STORE;
      5: return OPC_BRANCH;
      6: return OPC_JAL;
      default: return OPC_LUI;
    endcase
  endfunction

  // Mostly well-formed words with random content; the rest is noise that often
  // lands on unhandled opcodes.
  function automatic logic [INSTR_W-1:0] random_instruction();
    logic [INSTR_W-1:0] w;
    int unsigned        pick;
    w = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      w[6:0] = pick_handled_opcode();
      if (w[6:0] == OPC_R && $urandom_range(0, 3) != 0)
        w[31:25] = $urandom_range(0, 1) ? F7_BASE : F7_ALT;
      if (w[6:0] == OPC_I_ALU && (w[14:12] == F3_SLL || w[14:12] == F3_SR) &&
          $urandom_range(0, 1) != 0)
        w[31:26] = $urandom_range(0, 1) ? 6'd0 : F7_ALT[6:1];
    end else if (pick < 95) begin
      w[1:0] = 2'b11;
    end
    return w;
  endfunction

  // Every result is compared with the oldest outstanding request.
  always @(posedge clk) begin : check_results
    decode_t want;
    decode_t got;
    if (!rst && done) begin
      got.handled = 1'b1;
      got.op = op_t'(op_id);
      got.lay = layout_t'(layout);
      got.rd = dest_reg;
      got.rs1 = src1_reg;
      got.rs2 = src2_reg;
      got.imm = immediate;
      if (pending_decodes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: result with no request outstanding: op %0d layout %0d", $time,
                   op_id, layout);
      end else begin
        want = pending_decodes.pop_front();
        results_checked++;
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: expected op %0d lay %0d rd %0d rs1 %0d rs2 %0d imm %0d",
                     $time, want.op, want.lay, want.rd, want.rs1, want.rs2, want.imm);
            $display("%0t:      got op %0d lay %0d rd %0d rs1 %0d rs2 %0d imm %0d",
                     $time, got.op, got.lay, got.rd, got.rs1, got.rs2, got.imm);
          end
        end
      end
    end
  end

  task automatic test_every_operation();
    max_gap = 1;
    send_fields(F7_BASE, F3_ADD, OPC_R, 1'b1);
    send_fields(F7_ALT,  F3_ADD, OPC_R, 1'b0);
    send_fields(F7_BASE, F3_XOR, OPC_R, 1'b1);
    send_fields(F7_BASE, F3_OR,  OPC_R, 1'b0);
    send_fields(F7_BASE, F3_AND, OPC_R, 1'b1);
    send_fields(F7_BASE, F3_SLL, OPC_R, 1'b0);
    send_fields(F7_BASE, F3_SR,  OPC_R, 1'b1);
    send_fields(F7_ALT,  F3_SR,  OPC_R, 1'b0);
    // Immediate extremes: -1, -2048, 2047 and 0.
    send_fields(7'h7f, F3_ADD, OPC_I_ALU, 1'b1);
    send_fields(7'h40, F3_XOR, OPC_I_ALU, 1'b0);
    send_fields(7'h3f, F3_OR,  OPC_I_ALU, 1'b1);
    send_fields(7'h00, F3_AND, OPC_I_ALU, 1'b0);
    send_fields(7'h01, F3_SLL, OPC_I_ALU, 1'b1);
    send_fields(7'h01, F3_SR,  OPC_I_ALU, 1'b1);
    send_fields(F7_ALT, F3_SR, OPC_I_ALU, 1'b0);
    for (int f3 = 0; f3 <= F3_LWU; f3++)
      send_fields((f3 % 2 == 0) ? 7'h7f : 7'h00, f3[2:0], OPC_LOAD, f3 % 2 == 0);
    send_fields(7'h7f, F3_ADD, OPC_JALR, 1'b1);
    for (int f3 = 0; f3 <= F3_SD; f3++)
      send_fields((f3 % 2 == 0) ? 7'h40 : 7'h3f, f3[2:0], OPC_STORE, f3 % 2 != 0);
    send_fields(7'h7f, F3_BEQ,  OPC_BRANCH, 1'b1);
    send_fields(7'h00, F3_BNE,  OPC_BRANCH, 1'b0);
    send_fields(7'h40, F3_BLT,  OPC_BRANCH, 1'b0);
    send_fields(7'h3f, F3_BGE,  OPC_BRANCH, 1'b1);
    send_fields(7'h7f, F3_BLTU, OPC_BRANCH, 1'b0);
    send_fields(7'h00, F3_BGEU, OPC_BRANCH, 1'b1);
    send_fields(7'h7f, F3_AND, OPC_JAL, 1'b1);
    send_fields(7'h00, F3_ADD, OPC_JAL, 1'b0);
    send_fields(7'h7f, F3_AND, OPC_LUI, 1'b1);
    wait_for_drain();
  endtask

  task automatic test_unknown_and_unhandled();
    max_gap = 3;
    send_fields(7'h01, F3_ADD, OPC_R, 1'b1);
    send_fields(F7_ALT, F3_XOR, OPC_R, 1'b0);
    send_fields(7'h7f, F3_SLL, OPC_I_ALU, 1'b1);
    send_fields(7'h40, F3_SR,  OPC_I_ALU, 1'b0);
    send_fields(7'h7f, F3_AND, OPC_LOAD, 1'b1);
    send_fields(7'h00, F3_XOR, OPC_STORE, 1'b1);
    send_fields(7'h7f, 3'b010, OPC_BRANCH, 1'b0);
    send_fields(7'h00, F3_AND, OPC_JALR, 1'b0);
    send_request('0);
    send_request('1);
    wait_for_drain();
  endtask

  // The sender holds off part way through until every outstanding result is in.
  task automatic test_pause_until_drained();
    max_gap = 0;
    repeat (20) send_request(random_instruction());
    wait_for_drain();
    repeat (20) send_request(random_instruction());
    wait_for_drain();
  endtask

  task automatic test_random_stream();
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // Mix back-to-back bursts with lightly and heavily gapped stretches, chosen at random.
      if (i % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: max_gap = 0;
          1: max_gap = 3;
          default: max_gap = 10;
        endcase
      end
      send_request(random_instruction());
    end
    wait_for_drain();
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    instr_word = '0;
    max_gap = 0;
    requests_sent = 0;
    results_checked = 0;
    words_without_result = 0;
    mismatch_count = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_every_operation();
    test_unknown_and_unhandled();
    test_pause_until_drained();
    test_random_stream();
    // Let any stray result from the two-stage pipeline show up.
    repeat (6) @(posedge clk);
    $display("Sent %0d instruction words: %0d decodes checked, %0d words with no result.",
             requests_sent, results_checked, words_without_result);
    $display("Mismatches found: %0d.", mismatch_count);
    if (mismatch_count == 0 && pending_decodes.size() == 0) begin
      $display("rv64i_instruction_decoder_unit_test: clean");
    end else begin
      $display("rv64i_instruction_decoder_unit_test: errors");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Timed out with %0d results still outstanding.", pending_decodes.size());
    $display("rv64i_instruction_decoder_unit_test: errors");
    $finish;
  end

endmodule
